>>> design/gfpa_pkg.sv
// Package for the growing free page allocator: defaults, fixed field widths,
// and the sequencer state type. No dependencies.
package gfpa_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_PAGES_DEF     = 1024;
   localparam int INITIAL_PAGES_DEF = 16;

   // Fixed widths of the stream fields
   localparam int PAGE_W  = 10;
   localparam int COUNT_W = 11;

   // Padded stream words
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   // Request kinds carried on tuser
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_INIT,   // link the initial pages after reset
      ST_IDLE,   // take a request word
      ST_POP,    // link memory read in flight for an allocate
      ST_GROW    // link the pages added by a pool doubling
   } state_type;

endpackage

>>> design/gfpa_link_ram.sv
// Link memory of the free list: one write port, one read port, registered
// read data. Depends on nothing but its parameters.
module gfpa_link_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [ADDR_W-1:0] rd_data
);

   logic [ADDR_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/growing_free_page_allocator_unit.sv
// Growing free page allocator: free list of pages kept in a link memory.
// Uses gfpa_pkg (defaults, widths, state type) and gfpa_link_ram.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+---------------------------------------
//   req     | in  | req_tvalid/tready  | tdata: page_id; tuser: kind
//   rsp     | out | rsp_tvalid/tready  | tdata: page, pool_pages; tuser: error
//
// A free is answered directly; an allocate reads the link memory, then pops.
// An allocate that finds the list empty and the pool not full first links
// the new pages, one memory write a cycle, then pops the first of them.
// After reset the initial pages are linked in the same way: the block takes
// no request until they are linked (INITIAL_PAGES clamped to 2 .. MAX_PAGES).
// One request is in work at a time; a new request enters only when the
// result register is empty or is being read on the same edge.
module growing_free_page_allocator_unit #(
   parameter int MAX_PAGES     = gfpa_pkg::MAX_PAGES_DEF,
   parameter int INITIAL_PAGES = gfpa_pkg::INITIAL_PAGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gfpa_pkg::REQ_DATA_W-1:0] req_tdata,  // [9:0] page_id, rest zero
   input  logic                            req_tuser,  // [0] kind
   // response
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gfpa_pkg::RSP_DATA_W-1:0] rsp_tdata,  // [9:0] page, [20:10] pool_pages
   output logic                            rsp_tuser   // [0] error
);

   localparam int IDX_W = $clog2(MAX_PAGES);
   localparam int CNT_W = $clog2(MAX_PAGES + 1);
   localparam int INIT_PAGES = (INITIAL_PAGES > MAX_PAGES) ? MAX_PAGES :
                               (INITIAL_PAGES < 2) ? 2 : INITIAL_PAGES;
   // wide enough for page_id and the page count side by side
   localparam int CMP_W = (gfpa_pkg::PAGE_W > CNT_W) ? gfpa_pkg::PAGE_W : CNT_W;

   // control state
   gfpa_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    head_ff, head_in;     // free list head, 0 = empty
   logic [CNT_W-1:0]    count_ff, count_in;   // pages in the pool
   logic [IDX_W-1:0]    ptr_ff, ptr_in;       // link sweep position
   logic [IDX_W-1:0]    last_ff, last_in;     // last page of the sweep
   logic                out_valid_ff, out_valid_in;

   // result payload
   logic [gfpa_pkg::PAGE_W-1:0]  out_page_ff, out_page_in;
   logic                         out_err_ff, out_err_in;
   logic [gfpa_pkg::COUNT_W-1:0] out_count_ff, out_count_in;

   // link memory ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_data;

   // request decode
   logic                        accept;
   logic                        out_free;   // result register free by next edge
   logic [gfpa_pkg::PAGE_W-1:0] req_page_id;
   logic [CMP_W-1:0]            id_wide;
   logic                        free_ok;
   logic                        list_empty;
   logic                        pool_full;
   logic [CNT_W:0]              count_dbl;
   logic [CNT_W:0]              grow_target;
   logic                        sweep_end;

   assign req_page_id = req_tdata[gfpa_pkg::PAGE_W-1:0];
   assign id_wide     = CMP_W'(req_page_id);
   assign out_free    = !out_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == gfpa_pkg::ST_IDLE) && out_free;
   assign accept      = req_tvalid && req_tready;
   assign free_ok     = (req_page_id != '0) && (id_wide < CMP_W'(count_ff));
   assign list_empty  = (head_ff == '0);
   assign pool_full   = (count_ff == CNT_W'(MAX_PAGES));
   assign count_dbl   = {count_ff, 1'b0};
   assign grow_target = (count_dbl > (CNT_W + 1)'(MAX_PAGES)) ?
                        (CNT_W + 1)'(MAX_PAGES) : count_dbl;
   assign sweep_end   = (ptr_ff == last_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gfpa_pkg::ST_INIT: begin
            if (sweep_end) state_in = gfpa_pkg::ST_IDLE;
         end
         gfpa_pkg::ST_IDLE: begin
            if (accept && req_tuser == gfpa_pkg::KIND_ALLOC) begin
               if (!list_empty)     state_in = gfpa_pkg::ST_POP;
               else if (!pool_full) state_in = gfpa_pkg::ST_GROW;
            end
         end
         gfpa_pkg::ST_POP: begin
            state_in = gfpa_pkg::ST_IDLE;
         end
         gfpa_pkg::ST_GROW: begin
            if (sweep_end) state_in = gfpa_pkg::ST_IDLE;
         end
         default: begin
            state_in = gfpa_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      ptr_in       = ptr_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_page_in  = out_page_ff;
      out_err_in   = out_err_ff;
      out_count_in = out_count_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      wr_data      = sweep_end ? '0 : ptr_ff + 1'b1;
      rd_en        = 1'b0;

      case (state_ff)
         gfpa_pkg::ST_INIT: begin
            // link page ptr to the next one, the last to none
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
         end
         gfpa_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser == gfpa_pkg::KIND_FREE) begin
                  // push: page_id links to the old head
                  out_valid_in = 1'b1;
                  out_page_in  = '0;
                  out_err_in   = !free_ok;
                  out_count_in = gfpa_pkg::COUNT_W'(count_ff);
                  if (free_ok) begin
                     wr_en   = 1'b1;
                     wr_addr = IDX_W'(id_wide);
                     wr_data = head_ff;
                     head_in = IDX_W'(id_wide);
                  end
               end else if (!list_empty) begin
                  // fetch the head's link, pop next cycle
                  rd_en = 1'b1;
               end else if (pool_full) begin
                  out_valid_in = 1'b1;
                  out_page_in  = '0;
                  out_err_in   = 1'b1;
                  out_count_in = gfpa_pkg::COUNT_W'(count_ff);
               end else begin
                  // sweep the new pages count .. target-1
                  ptr_in  = IDX_W'(count_ff);
                  last_in = IDX_W'(grow_target - 1'b1);
               end
            end
         end
         gfpa_pkg::ST_POP: begin
            out_valid_in = 1'b1;
            out_page_in  = gfpa_pkg::PAGE_W'(head_ff);
            out_err_in   = 1'b0;
            out_count_in = gfpa_pkg::COUNT_W'(count_ff);
            head_in      = rd_data;
         end
         gfpa_pkg::ST_GROW: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + 1'b1;
            if (sweep_end) begin
               // pop the first new page straight away; its link is known
               out_valid_in = 1'b1;
               out_page_in  = gfpa_pkg::PAGE_W'(count_ff);
               out_err_in   = 1'b0;
               out_count_in = gfpa_pkg::COUNT_W'(CNT_W'(last_ff) + 1'b1);
               count_in     = CNT_W'(last_ff) + 1'b1;
               head_in      = (IDX_W'(count_ff) == last_ff) ? '0 :
                              IDX_W'(count_ff) + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gfpa_pkg::ST_INIT;
         head_ff      <= IDX_W'(1);
         count_ff     <= CNT_W'(INIT_PAGES);
         ptr_ff       <= IDX_W'(1);
         last_ff      <= IDX_W'(INIT_PAGES - 1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_page_ff  <= out_page_in;
      out_err_ff   <= out_err_in;
      out_count_ff <= out_count_in;
   end

   gfpa_link_ram #(
      .DEPTH  (MAX_PAGES),
      .ADDR_W (IDX_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = gfpa_pkg::RSP_DATA_W'({out_count_ff, out_page_ff});
   assign rsp_tuser  = out_err_ff;

endmodule

>>> test/tb_growing_free_page_allocator_unit.sv
`timescale 1ns / 100ps
// Testbench for growing_free_page_allocator_unit: directed and random alloc/free words,
// with a free-list predictor and in-order response checking. Depends on gfpa_pkg.
module tb_growing_free_page_allocator_unit;

   localparam int MAX_PAGES     = gfpa_pkg::MAX_PAGES_DEF;
   localparam int INITIAL_PAGES = gfpa_pkg::INITIAL_PAGES_DEF;
   // Reset pool size, clamped as the block does
   localparam int INIT_COUNT = (INITIAL_PAGES > MAX_PAGES) ? MAX_PAGES :
                               (INITIAL_PAGES < 2) ? 2 : INITIAL_PAGES;
   localparam int BACKLOG_DEPTH = 4;    // words queued ahead of the driver
   localparam int HOLD_LEN      = 300;  // long receiver stall, in cycles
   localparam int DRAIN_CYCLES  = 20;

   typedef struct packed {
      logic                        kind;
      logic [gfpa_pkg::PAGE_W-1:0] page_id;
   } page_req_type;

   typedef struct packed {
      logic [gfpa_pkg::PAGE_W-1:0]  page;
      logic                         error;
      logic [gfpa_pkg::COUNT_W-1:0] pool_pages;
   } page_rsp_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [gfpa_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // [9:0] page_id, rest zero
   logic                            req_tuser = gfpa_pkg::KIND_ALLOC; // [0] kind
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [gfpa_pkg::RSP_DATA_W-1:0] rsp_tdata;        // [9:0] page, [20:10] pool_pages
   logic                            rsp_tuser;        // [0] error

   growing_free_page_allocator_unit #(
      .MAX_PAGES    (MAX_PAGES),
      .INITIAL_PAGES(INITIAL_PAGES)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #10 clock = ~clock;

   // Shadow of the allocator: link memory, list head, pool size
   logic [gfpa_pkg::PAGE_W-1:0] link_shadow [MAX_PAGES];
   int unsigned                 head_shadow;
   int unsigned                 count_shadow;

   page_req_type req_backlog[$];     // words waiting for the driver
   page_rsp_type predicted_rsp[$];   // responses owed by the block, oldest first
   int unsigned  held_pages[$];      // pages handed out and not yet freed
   int unsigned  freed_pages[$];     // recent frees, reused for double frees
   int           mismatches = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           hold_cycles;
   logic         hold_trigger = 1'b0;
   logic         pool_full_seen = 1'b0;
   int unsigned  last_pool_pages = INIT_COUNT;

   // Link pages lo .. hi-1 ascending; the last one ends the list.
   function automatic void link_pages(int unsigned lo, int unsigned hi);
      for (int unsigned p = lo; p < hi; p++)
         link_shadow[p] = (p + 1 < hi) ? gfpa_pkg::PAGE_W'(p + 1) : '0;
   endfunction

   function automatic void reset_free_list();
      foreach (link_shadow[i])
         link_shadow[i] = '0;
      link_pages(1, INIT_COUNT);
      head_shadow  = 1;
      count_shadow = INIT_COUNT;
   endfunction

   // Apply one request to the shadow and return the response it owes.
   function automatic page_rsp_type apply_page_request(logic kind,
                                                       logic [gfpa_pkg::PAGE_W-1:0] page_id);
      page_rsp_type rsp;
      int unsigned  target;
      rsp = '0;
      if (kind == gfpa_pkg::KIND_ALLOC) begin
         // Empty list: double the pool first, saturating at the maximum
         if (head_shadow == 0) begin
            target = (count_shadow * 2 > MAX_PAGES) ? MAX_PAGES : count_shadow * 2;
            if (target > count_shadow) begin
               link_pages(count_shadow, target);
               head_shadow  = count_shadow;
               count_shadow = target;
            end
         end
         if (head_shadow == 0) begin
            rsp.error = 1'b1;   // pool full
         end else begin
            rsp.page    = gfpa_pkg::PAGE_W'(head_shadow);
            head_shadow = 32'(link_shadow[head_shadow]);
         end
      end else if (page_id == 0 || page_id >= count_shadow) begin
         rsp.error = 1'b1;      // reserved page or beyond the pool
      end else begin
         // No double-free check: push whatever page comes in
         link_shadow[page_id] = gfpa_pkg::PAGE_W'(head_shadow);
         head_shadow          = 32'(page_id);
      end
      rsp.pool_pages = gfpa_pkg::COUNT_W'(count_shadow);
      return rsp;
   endfunction

   // Driver: predict each accepted word, then offer the next one or idle.
   // Valid only drops after an accept, so an offered word is always held.
   always @(posedge clock) begin
      page_req_type next_word;
      page_rsp_type owed;
      if (reset) begin
         reset_free_list();
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            owed = apply_page_request(req_tuser, req_tdata[gfpa_pkg::PAGE_W-1:0]);
            predicted_rsp.push_back(owed);
         end
         if (!req_tvalid || req_tready) begin
            if (req_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_word  = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(gfpa_pkg::REQ_DATA_W - gfpa_pkg::PAGE_W){1'b0}},
                              next_word.page_id};
               req_tuser  <= next_word.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver stall, counted here so the driver keeps pushing into it
   always @(posedge clock) begin
      if (reset) begin
         hold_cycles <= 0;
      end else if (hold_trigger && hold_cycles == 0) begin
         hold_cycles <= HOLD_LEN;
      end else if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && hold_cycles == 0 && $urandom_range(99, 0) >= recv_idle_pct;
   end

   task automatic report_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Monitor: compare each response word with the oldest prediction
   always @(posedge clock) begin
      page_rsp_type got;
      page_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.page       = rsp_tdata[gfpa_pkg::PAGE_W-1:0];
         got.pool_pages = rsp_tdata[gfpa_pkg::PAGE_W +: gfpa_pkg::COUNT_W];
         got.error      = rsp_tuser;
         if (predicted_rsp.size() == 0) begin
            $display("%0t ns: response expected none, actual page %0d error %0d pool %0d",
                     $time, got.page, got.error, got.pool_pages);
            mismatches++;
         end else begin
            want = predicted_rsp.pop_front();
            report_field("page", 32'(want.page), 32'(got.page));
            report_field("error", 32'(want.error), 32'(got.error));
            report_field("pool_pages", 32'(want.pool_pages), 32'(got.pool_pages));
            // Feed the stimulus: pages now owned by the sender, and the pool size
            if (!want.error && want.page != 0)
               held_pages.push_back(32'(want.page));
            last_pool_pages = 32'(want.pool_pages);
            if (want.pool_pages == MAX_PAGES)
               pool_full_seen = 1'b1;
         end
      end
   end

   // Queue one word, keeping only a few ahead so frees can follow allocations
   task automatic queue_request(logic kind, int unsigned page_id);
      while (req_backlog.size() >= BACKLOG_DEPTH)
         @(negedge clock);
      req_backlog.push_back('{kind: kind, page_id: gfpa_pkg::PAGE_W'(page_id)});
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_tvalid || predicted_rsp.size() != 0)
         @(negedge clock);
   endtask

   // Pick a free page_id: mostly a held page, else noise that stays invalid
   // until the pool is full (a stray valid free would form a list cycle and
   // stop growth), and double frees once the pool is full.
   function automatic int unsigned pick_free_id();
      int unsigned sel;
      int unsigned idx;
      int unsigned id;
      sel = $urandom_range(99, 0);
      if (sel < 80 && held_pages.size() != 0) begin
         idx = $urandom_range(held_pages.size() - 1, 0);
         id  = held_pages[idx];
         held_pages.delete(idx);
         freed_pages.push_back(id);
         if (freed_pages.size() > 32)
            void'(freed_pages.pop_front());
      end else if (pool_full_seen && sel < 88 && freed_pages.size() != 0) begin
         id = freed_pages[$urandom_range(freed_pages.size() - 1, 0)];
      end else if (pool_full_seen) begin
         id = $urandom_range(MAX_PAGES - 1, 0);
      end else if (2 * last_pool_pages < MAX_PAGES && $urandom_range(3, 0) != 0) begin
         id = $urandom_range(MAX_PAGES - 1, 2 * last_pool_pages);
      end else begin
         id = 0;
      end
      return id;
   endfunction

   initial begin
      int phase_items [3] = '{600, 600, 500};
      int unsigned id;
      int          alloc_pct;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: invalid frees, drain the initial list, grow, free and reuse
      queue_request(gfpa_pkg::KIND_FREE, 0);
      queue_request(gfpa_pkg::KIND_FREE, INIT_COUNT);
      queue_request(gfpa_pkg::KIND_FREE, MAX_PAGES - 1);
      for (int n = 0; n < INIT_COUNT - 1; n++)
         queue_request(gfpa_pkg::KIND_ALLOC, (n == 0) ? MAX_PAGES - 1 : 0);
      queue_request(gfpa_pkg::KIND_ALLOC, 0);   // list empty: pool doubles
      wait_idle();
      id = held_pages.pop_back();
      queue_request(gfpa_pkg::KIND_FREE, id);
      queue_request(gfpa_pkg::KIND_ALLOC, 0);   // hands the same page back
      queue_request(gfpa_pkg::KIND_FREE, 2 * INIT_COUNT);

      // Random: allocation-heavy until the pool saturates, then balanced
      for (int phase = 0; phase < 3; phase++) begin
         @(negedge clock);
         case (phase)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 54;
            end
            1: begin
               send_idle_pct = 54;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_trigger  = 1'b1;
               @(negedge clock);
               hold_trigger  = 1'b0;
            end
         endcase
         for (int n = 0; n < phase_items[phase]; n++) begin
            alloc_pct = pool_full_seen ? 45 : 96;
            if ($urandom_range(99, 0) < alloc_pct)
               queue_request(gfpa_pkg::KIND_ALLOC, $urandom_range(MAX_PAGES - 1, 0));
            else
               queue_request(gfpa_pkg::KIND_FREE, pick_free_id());
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && predicted_rsp.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
